// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared checks for the mixer, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MWM_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MWM_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mwm_pkg
// shared constants and types of the mecanum wheel mixer
// ----------------------------------------------------------------------------
package mwm_pkg;

   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int FRACTION_BITS_DEF = 15;
   // quotient bits resolved per divider stage
   localparam int DIV_STEPS_PER_STAGE = 4;

   localparam logic [15:0] PWM_PERIOD_RESET = 16'd999;
   // pi/4 in heading units
   localparam logic [15:0] HEADING_OFFSET = 16'd8192;
   localparam logic [15:0] POWER_ONE = 16'd32768;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   typedef enum logic [1:0] {
      DIR_OFF = 2'd0,
      DIR_FWD = 2'd1,
      DIR_REV = 2'd2
   } dir_type;

endpackage

// ===== hdl/mwm_div_lane.sv =====
// ----------------------------------------------------------------------------
// mwm_div_lane
// pipelined restoring divider for one wheel: |w| * one / x, or |w| unscaled
// ----------------------------------------------------------------------------
module mwm_div_lane #(
   parameter int FractionBits = mwm_pkg::FRACTION_BITS_DEF
) (
   input  logic                    clock,
   input  logic [FractionBits+1:0] in_num,
   input  logic [FractionBits+1:0] in_den,
   input  logic                    in_scale,
   input  logic                    in_neg,
   output logic [FractionBits:0]   out_mag,
   output logic                    out_neg
);
   import mwm_pkg::*;

   localparam int QW = FractionBits + 1;
   localparam int RW = FractionBits + 3;
   localparam int NS = (QW + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

   logic [RW-1:0] rem_src   [NS+1];
   logic [RW-1:0] den_src   [NS+1];
   logic [QW-1:0] quo_src   [NS+1];
   logic [QW-1:0] pass_src  [NS+1];
   logic          scale_src [NS+1];
   logic          neg_src   [NS+1];

   assign rem_src[0]   = RW'(in_num);
   assign den_src[0]   = RW'(in_den);
   assign quo_src[0]   = '0;
   assign pass_src[0]  = in_num[QW-1:0];
   assign scale_src[0] = in_scale;
   assign neg_src[0]   = in_neg;

   for (genvar st = 0; st < NS; st++) begin : g_stage
      logic [RW-1:0] rem_in;
      logic [QW-1:0] quo_in;
      logic [RW-1:0] rem_ff;
      logic [RW-1:0] den_ff;
      logic [QW-1:0] quo_ff;
      logic [QW-1:0] pass_ff;
      logic          scale_ff;
      logic          neg_ff;

      // a few quotient bits, msb first
      always_comb begin
         int k;
         rem_in = rem_src[st];
         quo_in = quo_src[st];
         for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
            k = st * DIV_STEPS_PER_STAGE + j;
            if (k < QW) begin
               if (rem_in >= den_src[st]) begin
                  rem_in = rem_in - den_src[st];
                  quo_in[QW-1-k] = 1'b1;
               end
               rem_in = {rem_in[RW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff   <= rem_in;
         den_ff   <= den_src[st];
         quo_ff   <= quo_in;
         pass_ff  <= pass_src[st];
         scale_ff <= scale_src[st];
         neg_ff   <= neg_src[st];
      end

      assign rem_src[st+1]   = rem_ff;
      assign den_src[st+1]   = den_ff;
      assign quo_src[st+1]   = quo_ff;
      assign pass_src[st+1]  = pass_ff;
      assign scale_src[st+1] = scale_ff;
      assign neg_src[st+1]   = neg_ff;
   end

   // unscaled demands never exceed one, so the pass value fits
   assign out_mag = scale_src[NS] ? quo_src[NS] : pass_src[NS];
   assign out_neg = neg_src[NS];

endmodule

// ===== hdl/mecanum_wheel_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_unit
// pipeline: stage 1, stage 2, the divider stages and the output register lie
//   between start and rsp_strobe; the fraction width sets the divider depth
// throughput: one item per cycle, busy is always low
// reset: synchronous, clears the pipeline valid bits and sets pwm period to 999
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mecanum_wheel_mixer_unit #(
   parameter int SineTableBits = mwm_pkg::SINE_TABLE_BITS_DEF,
   parameter int FractionBits  = mwm_pkg::FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_drive_power,
   input  logic [15:0]        req_heading,
   input  logic signed [15:0] req_turn_rate,
   // pwm period register
   input  logic               csr_write_en,
   input  logic [15:0]        csr_write_data,
   // result channel
   output logic               rsp_strobe,
   output logic               rsp_status,
   output mwm_pkg::dir_type   rsp_front_left_dir,
   output logic [15:0]        rsp_front_left_duty,
   output mwm_pkg::dir_type   rsp_front_right_dir,
   output logic [15:0]        rsp_front_right_duty,
   output mwm_pkg::dir_type   rsp_back_left_dir,
   output logic [15:0]        rsp_back_left_duty,
   output mwm_pkg::dir_type   rsp_back_right_dir,
   output logic [15:0]        rsp_back_right_duty
);
   import mwm_pkg::*;

   localparam int FB = FractionBits;
   localparam int PW = FB + 1;                  // magnitude up to one
   localparam int QB = SineTableBits - 2;
   localparam int Quarter = 1 << QB;
   localparam int NS = (PW + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
   localparam logic [FB+1:0] OneX = (FB+2)'(1) << FB;

   // ---------------------------------------------------------------------
   // elaboration-time sine table
   // ---------------------------------------------------------------------

   // quarter-wave sine, taylor series to x^13 in q30, rounded to FB bits
   function automatic logic [63:0] quarter_sine(input int unsigned q);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x  = (64'(q) * HALF_PI_Q30) >> QB;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      s  = (s + (64'd1 << (29 - FB))) >> (30 - FB);
      return s;
   endfunction

   // magnitude of sin(q) or sin(quarter-q) divided by the larger of the two
   function automatic logic [FB:0] norm_mag(input int unsigned q, input logic cos_side);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] m;
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] quo;
      a   = quarter_sine(q);
      b   = quarter_sine(Quarter - q);
      num = cos_side ? b : a;
      m   = (a > b) ? a : b;
      if (m == 64'd0) begin
         m = 64'd1;
      end
      num = num << FB;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= m) begin
            rem    = rem - m;
            quo[i] = 1'b1;
         end
      end
      return quo[FB:0];
   endfunction

   logic [FB:0] ns_tab [Quarter];
   logic [FB:0] nc_tab [Quarter];

   for (genvar gi = 0; gi < Quarter; gi++) begin : g_tab
      assign ns_tab[gi] = norm_mag(gi, 1'b0);
      assign nc_tab[gi] = norm_mag(gi, 1'b1);
   end

   // ---------------------------------------------------------------------
   // pwm period register
   // ---------------------------------------------------------------------
   logic [15:0] period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PWM_PERIOD_RESET;
      end else if (csr_write_en) begin
         period_ff <= csr_write_data;
      end
   end

   // receiver cannot stall and every stage moves each cycle
   assign busy = 1'b0;

   // ---------------------------------------------------------------------
   // stage 1: scale inputs, look up normalized sin and cos
   // ---------------------------------------------------------------------
   logic [15:0]              hd_off;
   logic [SineTableBits-1:0] tab_idx;
   logic [1:0]               quad;
   logic [QB-1:0]            qpos;
   logic [16:0]              t_abs;
   logic [FB:0]              p_scaled;
   logic [FB:0]              t_scaled;

   assign hd_off  = req_heading - HEADING_OFFSET;
   assign tab_idx = hd_off[15 -: SineTableBits];
   assign quad    = tab_idx[SineTableBits-1 -: 2];
   assign qpos    = tab_idx[QB-1:0];
   assign t_abs   = req_turn_rate[15] ? (17'd0 - {1'b1, req_turn_rate})
                                      : {1'b0, req_turn_rate};

   // q1.15 to internal fraction width, truncating magnitudes
   if (FractionBits >= 15) begin : g_up
      assign p_scaled = PW'({16'd0, req_drive_power} << (FractionBits - 15));
      assign t_scaled = PW'({15'd0, t_abs} << (FractionBits - 15));
   end else begin : g_dn
      assign p_scaled = PW'(req_drive_power >> (15 - FractionBits));
      assign t_scaled = PW'(t_abs >> (15 - FractionBits));
   end

   logic          s1_vld_ff;
   logic          s1_inv_ff;
   logic [FB:0]   s1_p_ff;
   logic [FB:0]   s1_tmag_ff;
   logic          s1_tneg_ff;
   logic [FB:0]   s1_smag_ff;
   logic          s1_sneg_ff;
   logic [FB:0]   s1_cmag_ff;
   logic          s1_cneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
      end
   end

   // odd quadrants swap which side is the larger; signs follow the quadrant
   always_ff @(posedge clock) begin
      s1_inv_ff  <= req_drive_power > POWER_ONE;
      s1_p_ff    <= p_scaled;
      s1_tmag_ff <= t_scaled;
      s1_tneg_ff <= req_turn_rate[15];
      s1_smag_ff <= quad[0] ? nc_tab[qpos] : ns_tab[qpos];
      s1_cmag_ff <= quad[0] ? ns_tab[qpos] : nc_tab[qpos];
      s1_sneg_ff <= quad[1];
      s1_cneg_ff <= quad[0] ^ quad[1];
   end

   // ---------------------------------------------------------------------
   // stage 2: power products and wheel demands
   // ---------------------------------------------------------------------
   logic [2*PW-1:0]          ps_prod;
   logic [2*PW-1:0]          pc_prod;
   logic signed [FB+3:0]     ps_val;
   logic signed [FB+3:0]     pc_val;
   logic signed [FB+3:0]     t_val;
   logic signed [FB+3:0]     w_val [4];
   logic [FB+1:0]            w_mag [4];

   assign ps_prod = s1_p_ff * s1_smag_ff;
   assign pc_prod = s1_p_ff * s1_cmag_ff;

   // truncate toward zero on the magnitude, then apply sign
   always_comb begin
      ps_val = $signed({3'b000, ps_prod[FB +: PW]});
      pc_val = $signed({3'b000, pc_prod[FB +: PW]});
      t_val  = $signed({3'b000, s1_tmag_ff});
      if (s1_sneg_ff) begin
         ps_val = -ps_val;
      end
      if (s1_cneg_ff) begin
         pc_val = -pc_val;
      end
      if (s1_tneg_ff) begin
         t_val = -t_val;
      end
      // front left, front right, back left, back right
      w_val[0] = pc_val + t_val;
      w_val[1] = ps_val - t_val;
      w_val[2] = ps_val + t_val;
      w_val[3] = pc_val - t_val;
      for (int k = 0; k < 4; k++) begin
         w_mag[k] = w_val[k][FB+3] ? (FB+2)'(-w_val[k]) : w_val[k][FB+1:0];
      end
   end

   logic          s2_vld_ff;
   logic          s2_inv_ff;
   logic [FB+1:0] s2_wmag_ff [4];
   logic          s2_wneg_ff [4];
   logic [FB+1:0] s2_x_ff;
   logic          s2_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // every demand is bounded by p + |t|, so the divided magnitude never exceeds one
   always_ff @(posedge clock) begin
      s2_inv_ff   <= s1_inv_ff;
      s2_x_ff     <= {1'b0, s1_p_ff} + {1'b0, s1_tmag_ff};
      s2_scale_ff <= ({1'b0, s1_p_ff} + {1'b0, s1_tmag_ff}) > OneX;
      for (int k = 0; k < 4; k++) begin
         s2_wmag_ff[k] <= w_mag[k];
         s2_wneg_ff[k] <= w_val[k][FB+3];
      end
   end

   // ---------------------------------------------------------------------
   // stages 3 to 2+NS: scale-down divide, one lane per wheel
   // ---------------------------------------------------------------------
   logic [FB:0] dv_mag [4];
   logic        dv_neg [4];

   for (genvar gw = 0; gw < 4; gw++) begin : g_lane
      mwm_div_lane #(
         .FractionBits (FractionBits)
      ) u_div (
         .clock    (clock),
         .in_num   (s2_wmag_ff[gw]),
         .in_den   (s2_x_ff),
         .in_scale (s2_scale_ff),
         .in_neg   (s2_wneg_ff[gw]),
         .out_mag  (dv_mag[gw]),
         .out_neg  (dv_neg[gw])
      );
   end

   // valid and invalid-power flags ride alongside the divider
   logic dv_vld_ff [NS];
   logic dv_inv_ff [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            dv_vld_ff[i] <= 1'b0;
         end
      end else begin
         dv_vld_ff[0] <= s2_vld_ff;
         for (int i = 1; i < NS; i++) begin
            dv_vld_ff[i] <= dv_vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dv_inv_ff[0] <= s2_inv_ff;
      for (int i = 1; i < NS; i++) begin
         dv_inv_ff[i] <= dv_inv_ff[i-1];
      end
   end

   // ---------------------------------------------------------------------
   // last stage: duty = |w| * period, direction code, output register
   // ---------------------------------------------------------------------
   logic [PW+15:0] duty_prod [4];
   dir_type        dir_in    [4];
   logic [15:0]    duty_in   [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         duty_prod[k] = dv_mag[k] * period_ff;
         if (dv_inv_ff[NS-1] || dv_mag[k] == '0) begin
            dir_in[k] = DIR_OFF;
         end else if (dv_neg[k]) begin
            dir_in[k] = DIR_REV;
         end else begin
            dir_in[k] = DIR_FWD;
         end
         duty_in[k] = dv_inv_ff[NS-1] ? 16'd0 : duty_prod[k][FB +: 16];
      end
   end

   logic        rsp_strobe_ff;
   logic        rsp_status_ff;
   dir_type     rsp_dir_ff  [4];
   logic [15:0] rsp_duty_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= dv_inv_ff[NS-1];
      for (int k = 0; k < 4; k++) begin
         rsp_dir_ff[k]  <= dir_in[k];
         rsp_duty_ff[k] <= duty_in[k];
      end
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_front_left_dir   = rsp_dir_ff[0];
   assign rsp_front_left_duty  = rsp_duty_ff[0];
   assign rsp_front_right_dir  = rsp_dir_ff[1];
   assign rsp_front_right_duty = rsp_duty_ff[1];
   assign rsp_back_left_dir    = rsp_dir_ff[2];
   assign rsp_back_left_duty   = rsp_duty_ff[2];
   assign rsp_back_right_dir   = rsp_dir_ff[3];
   assign rsp_back_right_duty  = rsp_duty_ff[3];

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   `MWM_ASSERT_IMPL(a_invalid_zero, rsp_strobe && rsp_status,
      rsp_front_left_duty == 16'd0 && rsp_front_right_duty == 16'd0
         && rsp_back_left_duty == 16'd0 && rsp_back_right_duty == 16'd0
         && rsp_front_left_dir == DIR_OFF && rsp_back_right_dir == DIR_OFF,
      "invalid power item carries wheel data")
   `MWM_ASSERT_IMPL(a_off_no_duty,
      rsp_strobe && (rsp_front_left_dir == DIR_OFF || rsp_back_right_dir == DIR_OFF),
      (rsp_front_left_dir != DIR_OFF || rsp_front_left_duty == 16'd0)
         && (rsp_back_right_dir != DIR_OFF || rsp_back_right_duty == 16'd0),
      "stopped wheel with nonzero duty")
   `MWM_ASSERT_IMPL(a_duty_range, rsp_strobe,
      rsp_front_left_duty <= period_ff && rsp_front_right_duty <= period_ff
         && rsp_back_left_duty <= period_ff && rsp_back_right_duty <= period_ff,
      "duty above pwm period")
   `MWM_ASSERT_NEXT(a_csr_write, csr_write_en, period_ff == $past(csr_write_data),
      "pwm period write lost")

endmodule
